[hw/rtl/bsf_pkg.sv]
package bsf_pkg;

  localparam int unsigned ACC_W = 48;
  localparam int unsigned DIV_W = 64;

  // Input command codes
  localparam logic CMD_NBR = 1'b0;
  localparam logic CMD_FIN = 1'b1;

  // Configuration register indexes
  localparam logic REG_SIGHT = 1'b0;
  localparam logic REG_FORCE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEP_X,
    ST_SEP_Y,
    ST_NBR_DONE,
    ST_COH_X,
    ST_COH_Y,
    ST_VEC,
    ST_SQRT,
    ST_DIV_X,
    ST_DIV_Y,
    ST_VEC_DONE,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    DOP_SEP_X,
    DOP_SEP_Y,
    DOP_COH_X,
    DOP_COH_Y,
    DOP_LEN_X,
    DOP_LEN_Y
  } div_op_e;

  typedef struct packed {
    logic            start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  // Saturating add of a term that may lie well outside the accumulator range
  function automatic logic signed [ACC_W-1:0] sat_add_wide(
    input logic signed [ACC_W-1:0] a,
    input logic signed [DIV_W:0]   b
  );
    logic signed [DIV_W+1:0]    s;
    logic [DIV_W-ACC_W+2:0]     top;
    s   = {{(DIV_W+2-ACC_W){a[ACC_W-1]}}, a} + {b[DIV_W], b};
    top = s[DIV_W+1:ACC_W-1];
    if (top != '0 && top != '1) begin
      return top[DIV_W-ACC_W+2] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

[hw/rtl/bsf_if.sv]
interface bsf_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] self_x;
  logic signed [31:0] self_y;
  logic signed [31:0] nbr_x;
  logic signed [31:0] nbr_y;
  logic signed [31:0] nbr_vx;
  logic signed [31:0] nbr_vy;
  modport source (output valid, cmd, self_x, self_y, nbr_x, nbr_y, nbr_vx, nbr_vy,
                  input ready);
  modport sink (input valid, cmd, self_x, self_y, nbr_x, nbr_y, nbr_vx, nbr_vy,
                output ready);
endinterface

interface bsf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sep_x;
  logic signed [31:0] sep_y;
  logic signed [31:0] ali_x;
  logic signed [31:0] ali_y;
  logic signed [31:0] coh_x;
  logic signed [31:0] coh_y;
  logic [8:0]         neighbor_count;
  logic               dropped;
  modport source (output valid, sep_x, sep_y, ali_x, ali_y, coh_x, coh_y,
                  neighbor_count, dropped, input ready);
  modport sink (input valid, sep_x, sep_y, ali_x, ali_y, coh_x, coh_y,
                neighbor_count, dropped, output ready);
endinterface

interface bsf_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/bsf_divider.sv]
// Unsigned restoring divider, one quotient bit per cycle.
module bsf_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsf_pkg::div_req_t req_i,
  output bsf_pkg::div_rsp_t rsp_o
);
  localparam int unsigned W = bsf_pkg::DIV_W;

  logic [W-1:0]         quo_q, quo_d, den_q, den_d;
  logic [W:0]           rem_q, rem_d;
  logic [$clog2(W):0]   cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [W:0]           trial;

  // Shift in one numerator bit and try a subtract
  always_comb begin
    trial  = {rem_q[W-1:0], quo_q[W-1]};
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ($clog2(W)+1)'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule

[hw/rtl/boid_steering_forces.sv]
// Flocking steering forces for one boid. A neighbor word (cmd 0) runs two
// 64-step divisions of the separation offset by sight_radius in the shared
// bit-serial divider; a zero offset skips them. A finish word (cmd 1) runs,
// before its result word is offered, two averaging divisions for cohesion,
// then for each of the three force vectors a 32-step square root and
// two 64-step divisions, all through the same divider and one root step per
// cycle. A zero vector skips its root and divisions; a finish word with no
// neighbors skips all of them. The block takes no word while it works; the
// result word is held until taken, which adds any output stall to the finish
// time. Neighbors beyond MAX_NEIGHBORS are dropped and flagged.
module boid_steering_forces #(
  parameter int unsigned MAX_NEIGHBORS = 256,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  bsf_in_if.sink    in_i,
  bsf_out_if.source out_o,
  bsf_cfg_if.sink   cfg_i
);
  localparam int unsigned AW = bsf_pkg::ACC_W;
  localparam int unsigned DW = bsf_pkg::DIV_W;
  localparam int unsigned CW = $clog2(MAX_NEIGHBORS + 1);

  bsf_pkg::state_e state_q, state_d;
  bsf_pkg::div_req_t div_req;
  bsf_pkg::div_rsp_t div_rsp;

  logic [30:0] radius_q, force_q;
  logic signed [AW-1:0] sep_x_q, sep_y_q, vel_x_q, vel_y_q, pos_x_q, pos_y_q;
  logic [CW-1:0] cnt_q;
  logic          ovf_q;
  logic signed [31:0] self_x_q, self_y_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [AW-1:0] cx_q, cy_q;
  logic [1:0]  vec_q;
  logic [31:0] ax_q, ay_q;
  logic        negx_q, negy_q;
  logic [63:0] rv_q, rr_q, rb_q;
  logic [31:0] res_q [6];
  logic        busy_wait_q;
  logic        out_v_q;

  // Divider wiring
  bsf_divider u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // Current vector under set_length
  logic signed [AW-1:0] vx, vy;
  logic [AW-1:0] mx, my, mm;
  always_comb begin
    case (vec_q)
      2'd0:    begin vx = sep_x_q; vy = sep_y_q; end
      2'd1:    begin vx = vel_x_q; vy = vel_y_q; end
      default: begin vx = cx_q;    vy = cy_q;    end
    endcase
    mx = vx[AW-1] ? AW'(-vx) : AW'(vx);
    my = vy[AW-1] ? AW'(-vy) : AW'(vy);
    mm = (mx > my) ? mx : my;
  end

  // Normalize so the larger magnitude lies in [2^30, 2^31)
  logic [5:0] lead;
  logic [AW-1:0] nx_n, ny_n;
  always_comb begin
    lead = '0;
    for (int i = 0; i < AW; i++) if (mm[i]) lead = 6'(i);
    if (lead > 6'd30) begin
      nx_n = mx >> (lead - 6'd30);
      ny_n = my >> (lead - 6'd30);
    end else begin
      nx_n = mx << (6'd30 - lead);
      ny_n = my << (6'd30 - lead);
    end
  end

  // Separation and cohesion dividend magnitudes and the sight divisor
  logic signed [32:0] dsel;
  logic [32:0] dmag;
  logic [30:0] rad_eff;
  logic signed [AW-1:0] psel;
  logic [AW-1:0] pmag;
  logic signed [DW:0] sep_mag, sep_term;
  always_comb begin
    dsel     = (state_q == bsf_pkg::ST_SEP_X) ? dx_q : dy_q;
    dmag     = dsel[32] ? 33'(-dsel) : 33'(dsel);
    rad_eff  = (radius_q == '0) ? 31'd1 : radius_q;
    psel     = (state_q == bsf_pkg::ST_COH_X) ? pos_x_q : pos_y_q;
    pmag     = psel[AW-1] ? AW'(-psel) : AW'(psel);
    sep_mag  = $signed({1'b0, div_rsp.quo});
    sep_term = dsel[32] ? -sep_mag : sep_mag;
  end

  // Square root step
  logic [63:0] rtrial;
  assign rtrial = rr_q + rb_q;

  logic acc_in, cfg_wr, out_take, dz;
  assign in_i.ready  = (state_q == bsf_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign acc_in   = in_i.valid && in_i.ready;
  assign cfg_wr   = cfg_i.valid && cfg_i.ready;
  assign out_take = out_o.valid && out_o.ready;
  assign dz       = (dx_q == '0) && (dy_q == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bsf_pkg::ST_IDLE:
        if (acc_in) begin
          if (in_i.cmd == bsf_pkg::CMD_FIN)
            state_d = (cnt_q == '0) ? bsf_pkg::ST_OUT : bsf_pkg::ST_COH_X;
          else if (cnt_q < CW'(MAX_NEIGHBORS)) state_d = bsf_pkg::ST_SEP_X;
        end
      bsf_pkg::ST_SEP_X:
        if (dz) state_d = bsf_pkg::ST_NBR_DONE;
        else if (busy_wait_q && div_rsp.done) state_d = bsf_pkg::ST_SEP_Y;
      bsf_pkg::ST_SEP_Y:
        if (busy_wait_q && div_rsp.done) state_d = bsf_pkg::ST_NBR_DONE;
      bsf_pkg::ST_NBR_DONE: state_d = bsf_pkg::ST_IDLE;
      bsf_pkg::ST_COH_X:
        if (busy_wait_q && div_rsp.done) state_d = bsf_pkg::ST_COH_Y;
      bsf_pkg::ST_COH_Y:
        if (busy_wait_q && div_rsp.done) state_d = bsf_pkg::ST_VEC;
      bsf_pkg::ST_VEC:
        state_d = (mm == '0) ? bsf_pkg::ST_VEC_DONE : bsf_pkg::ST_SQRT;
      bsf_pkg::ST_SQRT:
        if (rb_q == '0) state_d = bsf_pkg::ST_DIV_X;
      bsf_pkg::ST_DIV_X:
        if (busy_wait_q && div_rsp.done) state_d = bsf_pkg::ST_DIV_Y;
      bsf_pkg::ST_DIV_Y:
        if (busy_wait_q && div_rsp.done) state_d = bsf_pkg::ST_VEC_DONE;
      bsf_pkg::ST_VEC_DONE:
        state_d = (vec_q == 2'd2) ? bsf_pkg::ST_OUT : bsf_pkg::ST_VEC;
      bsf_pkg::ST_OUT:
        if (out_take) state_d = bsf_pkg::ST_IDLE;
      default: state_d = bsf_pkg::ST_IDLE;
    endcase
  end

  // Divider requests
  logic div_go;
  always_comb begin
    div_go      = 1'b0;
    div_req.num = '0;
    div_req.den = '0;
    case (state_q)
      bsf_pkg::ST_SEP_X, bsf_pkg::ST_SEP_Y: begin
        div_go      = !busy_wait_q && !dz;
        div_req.num = DW'(dmag) << FRAC_BITS;
        div_req.den = DW'(rad_eff);
      end
      bsf_pkg::ST_COH_X, bsf_pkg::ST_COH_Y: begin
        div_go      = !busy_wait_q;
        div_req.num = DW'(pmag);
        div_req.den = DW'(cnt_q);
      end
      bsf_pkg::ST_DIV_X, bsf_pkg::ST_DIV_Y: begin
        div_go      = !busy_wait_q;
        div_req.num = DW'((state_q == bsf_pkg::ST_DIV_X ? ax_q : ay_q)) * DW'(force_q);
        div_req.den = rr_q;
      end
      default: div_go = 1'b0;
    endcase
    div_req.start = div_go;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsf_pkg::ST_IDLE;
      radius_q    <= 31'd9830400;
      force_q     <= 31'd19660800;
      sep_x_q     <= '0; sep_y_q <= '0;
      vel_x_q     <= '0; vel_y_q <= '0;
      pos_x_q     <= '0; pos_y_q <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      busy_wait_q <= 1'b0;
      out_v_q     <= 1'b0;
      vec_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (cfg_i.index == bsf_pkg::REG_SIGHT) radius_q <= cfg_i.data[30:0];
        else force_q <= cfg_i.data[30:0];
      end
      if (div_go) busy_wait_q <= 1'b1;
      else if (div_rsp.done) busy_wait_q <= 1'b0;
      if (acc_in && in_i.cmd == bsf_pkg::CMD_NBR) begin
        if (cnt_q < CW'(MAX_NEIGHBORS)) begin
          vel_x_q <= bsf_pkg::sat_add(vel_x_q, AW'(in_i.nbr_vx));
          vel_y_q <= bsf_pkg::sat_add(vel_y_q, AW'(in_i.nbr_vy));
          pos_x_q <= bsf_pkg::sat_add(pos_x_q, AW'(in_i.nbr_x));
          pos_y_q <= bsf_pkg::sat_add(pos_y_q, AW'(in_i.nbr_y));
        end else begin
          ovf_q <= 1'b1;
        end
      end
      // Add separation quotient when each division lands, or 100 for a zero offset
      if (state_q == bsf_pkg::ST_SEP_X && dz) begin
        sep_x_q <= bsf_pkg::sat_add(sep_x_q, AW'(100) <<< FRAC_BITS);
      end else if (busy_wait_q && div_rsp.done &&
                   (state_q == bsf_pkg::ST_SEP_X || state_q == bsf_pkg::ST_SEP_Y)) begin
        if (state_q == bsf_pkg::ST_SEP_X)
          sep_x_q <= bsf_pkg::sat_add_wide(sep_x_q, sep_term);
        else
          sep_y_q <= bsf_pkg::sat_add_wide(sep_y_q, sep_term);
      end
      if (state_q == bsf_pkg::ST_NBR_DONE) cnt_q <= cnt_q + 1'b1;
      if (acc_in && in_i.cmd == bsf_pkg::CMD_FIN) vec_q <= '0;
      if (state_q == bsf_pkg::ST_VEC_DONE) vec_q <= vec_q + 2'd1;
      // Emit and clear the sums
      if (state_d == bsf_pkg::ST_OUT && state_q != bsf_pkg::ST_OUT) out_v_q <= 1'b1;
      if (out_take) begin
        out_v_q <= 1'b0;
        sep_x_q <= '0; sep_y_q <= '0;
        vel_x_q <= '0; vel_y_q <= '0;
        pos_x_q <= '0; pos_y_q <= '0;
        cnt_q   <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      self_x_q <= in_i.self_x;
      self_y_q <= in_i.self_y;
      dx_q <= 33'(in_i.self_x) - 33'(in_i.nbr_x);
      dy_q <= 33'(in_i.self_y) - 33'(in_i.nbr_y);
      if (in_i.cmd == bsf_pkg::CMD_FIN) for (int i = 0; i < 6; i++) res_q[i] <= '0;
    end
    if (busy_wait_q && div_rsp.done) begin
      if (state_q == bsf_pkg::ST_COH_X)
        cx_q <= (pos_x_q[AW-1] ? -AW'(div_rsp.quo) : AW'(div_rsp.quo)) - AW'(self_x_q);
      if (state_q == bsf_pkg::ST_COH_Y)
        cy_q <= (pos_y_q[AW-1] ? -AW'(div_rsp.quo) : AW'(div_rsp.quo)) - AW'(self_y_q);
      if (state_q == bsf_pkg::ST_DIV_X)
        res_q[{vec_q, 1'b0}] <= negx_q ? -div_rsp.quo[31:0] : div_rsp.quo[31:0];
      if (state_q == bsf_pkg::ST_DIV_Y)
        res_q[{vec_q, 1'b1}] <= negy_q ? -div_rsp.quo[31:0] : div_rsp.quo[31:0];
    end
    // Load the root iteration
    if (state_q == bsf_pkg::ST_VEC) begin
      ax_q   <= nx_n[31:0];
      ay_q   <= ny_n[31:0];
      negx_q <= vx[AW-1];
      negy_q <= vy[AW-1];
      rv_q   <= 64'(nx_n[31:0]) * 64'(nx_n[31:0]) + 64'(ny_n[31:0]) * 64'(ny_n[31:0]);
      rr_q   <= '0;
      rb_q   <= 64'd1 << 62;
    end
    // One root digit per cycle
    if (state_q == bsf_pkg::ST_SQRT && rb_q != '0) begin
      if (rv_q >= rtrial) begin
        rv_q <= rv_q - rtrial;
        rr_q <= (rr_q >> 1) + rb_q;
      end else begin
        rr_q <= rr_q >> 1;
      end
      rb_q <= rb_q >> 2;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.sep_x          = res_q[0];
  assign out_o.sep_y          = res_q[1];
  assign out_o.ali_x          = res_q[2];
  assign out_o.ali_y          = res_q[3];
  assign out_o.coh_x          = res_q[4];
  assign out_o.coh_y          = res_q[5];
  assign out_o.neighbor_count = 9'(cnt_q);
  assign out_o.dropped        = ovf_q;
endmodule

[verif/tb_boid_steering_forces.sv]
module tb_boid_steering_forces;

  localparam int unsigned NBR_MAX   = 256;
  localparam int unsigned FRAC      = 16;
  localparam int unsigned IDLE_LIM  = 20000;
  localparam logic        CMD_NBR   = bsf_pkg::CMD_NBR;
  localparam logic        CMD_FIN   = bsf_pkg::CMD_FIN;
  localparam logic        REG_SIGHT = bsf_pkg::REG_SIGHT;
  localparam logic        REG_FORCE = bsf_pkg::REG_FORCE;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] self_x;
    logic signed [31:0] self_y;
    logic signed [31:0] nbr_x;
    logic signed [31:0] nbr_y;
    logic signed [31:0] nbr_vx;
    logic signed [31:0] nbr_vy;
  } nbr_word_t;

  typedef struct packed {
    logic signed [31:0] sep_x;
    logic signed [31:0] sep_y;
    logic signed [31:0] ali_x;
    logic signed [31:0] ali_y;
    logic signed [31:0] coh_x;
    logic signed [31:0] coh_y;
    logic [8:0]         neighbor_count;
    logic               dropped;
  } force_word_t;

  // Flock accumulator model and queue of pending force words
  class force_scoreboard;
    logic [30:0]         sight;
    logic [30:0]         fmax;
    logic signed [47:0]  sep_sx, sep_sy, vel_sx, vel_sy, pos_sx, pos_sy;
    int unsigned         nbrs;
    bit                  over;
    force_word_t         pending[$];
    int unsigned         errors;

    function new();
      sight = 31'd9830400;
      fmax  = 31'd19660800;
      errors = 0;
      clear();
    endfunction

    function void clear();
      sep_sx = '0; sep_sy = '0; vel_sx = '0; vel_sy = '0; pos_sx = '0; pos_sy = '0;
      nbrs = 0;
      over = 1'b0;
    endfunction

    function logic signed [47:0] sadd(logic signed [47:0] a, longint b);
      longint s;
      s = longint'(a) + b;
      if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
      if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
      return s[47:0];
    endfunction

    // Scale a vector to length fmax, keeping the sign of each component
    function void scale(longint x, longint y, output logic [31:0] ox, output logic [31:0] oy);
      longint unsigned ax, ay, m, v, r, b, rx, ry;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      if (ax == 0 && ay == 0) begin
        ox = '0; oy = '0;
        return;
      end
      m = ax > ay ? ax : ay;
      while (m >= 64'd1 << 31) begin ax >>= 1; ay >>= 1; m >>= 1; end
      while (m < 64'd1 << 30) begin ax <<= 1; ay <<= 1; m <<= 1; end
      v = ax * ax + ay * ay;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      rx = ax * fmax / r;
      ry = ay * fmax / r;
      ox = x < 0 ? 32'(-rx) : 32'(rx);
      oy = y < 0 ? 32'(-ry) : 32'(ry);
    endfunction

    function void note_word(nbr_word_t w);
      longint dx, dy, dv;
      force_word_t f;
      if (w.cmd == CMD_NBR) begin
        if (nbrs >= NBR_MAX) begin
          over = 1'b1;
          return;
        end
        dx = longint'(w.self_x) - longint'(w.nbr_x);
        dy = longint'(w.self_y) - longint'(w.nbr_y);
        dv = sight == 0 ? 1 : longint'(sight);
        if (dx == 0 && dy == 0) begin
          sep_sx = sadd(sep_sx, 100 * (64'sd1 << FRAC));
        end else begin
          sep_sx = sadd(sep_sx, (dx * (64'sd1 << FRAC)) / dv);
          sep_sy = sadd(sep_sy, (dy * (64'sd1 << FRAC)) / dv);
        end
        vel_sx = sadd(vel_sx, w.nbr_vx);
        vel_sy = sadd(vel_sy, w.nbr_vy);
        pos_sx = sadd(pos_sx, w.nbr_x);
        pos_sy = sadd(pos_sy, w.nbr_y);
        nbrs++;
        return;
      end
      f = '0;
      if (nbrs != 0) begin
        scale(sep_sx, sep_sy, f.sep_x, f.sep_y);
        scale(vel_sx, vel_sy, f.ali_x, f.ali_y);
        scale(longint'(pos_sx) / longint'(nbrs) - longint'(w.self_x),
              longint'(pos_sy) / longint'(nbrs) - longint'(w.self_y), f.coh_x, f.coh_y);
      end
      f.neighbor_count = 9'(nbrs);
      f.dropped = over;
      pending.push_back(f);
      clear();
    endfunction

    function void check_word(force_word_t got);
      force_word_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected force word %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp sep %0d %0d ali %0d %0d coh %0d %0d n %0d d %0b\n got sep %0d %0d ali %0d %0d coh %0d %0d n %0d d %0b",
                   exp.sep_x, exp.sep_y, exp.ali_x, exp.ali_y, exp.coh_x, exp.coh_y,
                   exp.neighbor_count, exp.dropped, got.sep_x, got.sep_y, got.ali_x,
                   got.ali_y, got.coh_x, got.coh_y, got.neighbor_count, got.dropped);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bsf_in_if  in_ch ();
  bsf_out_if out_ch ();
  bsf_cfg_if cfg_ch ();

  boid_steering_forces i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source),
    .cfg_i  (cfg_ch.sink)
  );

  force_scoreboard board;
  int unsigned     idle_cycles;
  bit              hold_out;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Drive one word and wait for its acceptance; valid stays up for the next word
  task automatic send_word(nbr_word_t w, bit gap);
    int unsigned g;
    g = gap ? $urandom_range(0, 16) : 0;
    if (g != 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= w.cmd;
    in_ch.self_x <= w.self_x;
    in_ch.self_y <= w.self_y;
    in_ch.nbr_x  <= w.nbr_x;
    in_ch.nbr_y  <= w.nbr_y;
    in_ch.nbr_vx <= w.nbr_vx;
    in_ch.nbr_vy <= w.nbr_vy;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_word(w);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_SIGHT) board.sight = val[30:0];
    else board.fmax = val[30:0];
  endtask

  // Drop valid, drain all pending force words and let a neighbor word finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom();
    endcase
  endfunction

  function automatic nbr_word_t rnd_word(logic cmd);
    nbr_word_t w;
    w.cmd = cmd;
    w.self_x = rnd_val(); w.self_y = rnd_val();
    w.nbr_x = rnd_val(); w.nbr_y = rnd_val();
    w.nbr_vx = rnd_val(); w.nbr_vy = rnd_val();
    if ($urandom_range(0, 9) == 0) begin
      w.nbr_x = w.self_x;
      w.nbr_y = w.self_y;
    end
    return w;
  endfunction

  // Output side: random wait per word, long hold-off on request
  initial begin
    int unsigned g;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        @(posedge clk_i);
      end else begin
        g = $urandom_range(0, 16);
        if (g != 0) begin
          out_ch.ready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
        out_ch.ready <= 1'b1;
        do @(posedge clk_i); while (!out_ch.valid);
        board.check_word({out_ch.sep_x, out_ch.sep_y, out_ch.ali_x, out_ch.ali_y,
                          out_ch.coh_x, out_ch.coh_y, out_ch.neighbor_count,
                          out_ch.dropped});
      end
    end
  end

  // Watchdog on cycles with no handshake
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else if (!hold_out)
        idle_cycles++;
      if (idle_cycles >= IDLE_LIM) begin
        $display("tb_boid_steering_forces: done, errors");
        $finish;
      end
    end
  end

  initial begin
    nbr_word_t w;
    int unsigned n, k;
    logic [31:0] sights[4];
    logic [31:0] forces[4];
    board = new();
    hold_out = 1'b0;
    rst_ni = 1'b0;
    in_ch.valid <= 1'b0; in_ch.cmd <= CMD_NBR;
    in_ch.self_x <= '0; in_ch.self_y <= '0; in_ch.nbr_x <= '0; in_ch.nbr_y <= '0;
    in_ch.nbr_vx <= '0; in_ch.nbr_vy <= '0;
    cfg_ch.valid <= 1'b0; cfg_ch.index <= REG_SIGHT; cfg_ch.data <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty finish, coincident positions, extremes
    send_word(rnd_word(CMD_FIN), 1'b0);
    w = '0;
    send_word(w, 1'b0);
    w.cmd = CMD_FIN;
    send_word(w, 1'b0);
    w = '{CMD_NBR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
          32'h7FFF_FFFF, 32'h8000_0000};
    repeat (3) send_word(w, 1'b0);
    w = '{CMD_NBR, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF};
    send_word(w, 1'b0);
    w.cmd = CMD_FIN;
    send_word(w, 1'b0);
    w = '{CMD_NBR, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0};
    send_word(w, 1'b0);
    w.cmd = CMD_FIN; w.self_x = 32'd65536;
    send_word(w, 1'b0);
    drain();

    // Overflow: two more neighbors than the bound, with a long output hold-off
    write_reg(REG_SIGHT, 32'd0);
    write_reg(REG_FORCE, 32'h7FFF_FFFF);
    for (k = 0; k < NBR_MAX + 2; k++) send_word(rnd_word(CMD_NBR), 1'b0);
    send_word(rnd_word(CMD_FIN), 1'b0);
    fork
      begin
        hold_out = 1'b1;
        repeat (2000) @(posedge clk_i);
        hold_out = 1'b0;
      end
      begin
        for (k = 0; k < 4; k++) begin
          send_word(rnd_word(CMD_NBR), 1'b0);
          send_word(rnd_word(CMD_FIN), 1'b0);
        end
        in_ch.valid <= 1'b0;
      end
    join
    drain();

    // Random phases across register settings
    sights = '{32'd65536, 32'h7FFF_FFFF, 32'd9830400, 32'($urandom())};
    forces = '{32'd0, 32'd1, 32'd19660800, 32'($urandom())};
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_SIGHT, sights[p]);
      write_reg(REG_FORCE, forces[p]);
      n = 0;
      while (n < 165) begin
        k = $urandom_range(0, 6);
        repeat (k) begin
          send_word(rnd_word(CMD_NBR), $urandom_range(0, 1));
          n++;
        end
        send_word(rnd_word(CMD_FIN), $urandom_range(0, 1));
        n++;
      end
      drain();
    end

    repeat (1000) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb_boid_steering_forces: done, clean");
    end else begin
      $display("tb_boid_steering_forces: done, errors");
    end
    $finish;
  end

endmodule
